// File: rtl/slrv_pkg.sv
package slrv_pkg;

	// request kinds carried on the input tuser
	typedef enum logic [1:0] {
		KIND_APPEND = 2'd0,
		KIND_UP     = 2'd1,
		KIND_DOWN   = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	// register indexes (byte address / 4)
	localparam logic REG_CHARS_PER_LINE = 1'b0;
	localparam logic REG_VISIBLE_LIMIT  = 1'b1;

	localparam logic [7:0] CHARS_PER_LINE_RST = 8'd80;
	localparam logic [7:0] VISIBLE_LIMIT_RST  = 8'd24;

	// live configuration handed to the datapath
	typedef struct packed {
		logic [7:0] chars_per_line;
		logic [7:0] visible_limit;
	} cfg_t;

endpackage

// File: rtl/slrv_apb_regs.sv
module slrv_apb_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output slrv_pkg::cfg_t     cfg
);

	logic [7:0] cpl_q;
	logic [7:0] vlim_q;
	logic       wr_en;
	logic       reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign wr_en   = psel && penable && pwrite && pready;

	// register writes on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpl_q  <= slrv_pkg::CHARS_PER_LINE_RST;
			vlim_q <= slrv_pkg::VISIBLE_LIMIT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				slrv_pkg::REG_CHARS_PER_LINE: cpl_q  <= pwdata[7:0];
				slrv_pkg::REG_VISIBLE_LIMIT:  vlim_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = 32'd0;
		unique case (reg_idx)
			slrv_pkg::REG_CHARS_PER_LINE: prdata = {24'd0, cpl_q};
			slrv_pkg::REG_VISIBLE_LIMIT:  prdata = {24'd0, vlim_q};
			default: prdata = 32'd0;
		endcase
	end

	assign cfg.chars_per_line = cpl_q;
	assign cfg.visible_limit  = vlim_q;

endmodule

// File: rtl/scrollback_line_ring_viewport.sv
// Channel   Direction  Contents
// s_*       in         tuser kind, tlast line_end, tdata char_code/amount/row_index/column
// m_*       out        tuser row_valid, tdata read_char/row_length/visible_count
// apb       in         reg 0 chars_per_line, reg 1 visible_limit
//
// One request is taken every cycle while s_tready is high. Pointer updates complete at the
// accepting edge; a read result passes through the registered memory read and then the
// output register. Reset clears the ring pointers and marks the ring empty; the row
// stores are not cleared, every row is written as it opens. A stalled result with a
// read waiting behind it holds off s_tready.
module scrollback_line_ring_viewport #(
	parameter int STORED_ROWS = 256,
	parameter int MAX_COLS    = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // char_code[7:0] amount[15:8] row_index[23:16] column[30:24]
	input  logic [1:0]  s_tuser,   // kind[1:0]
	input  logic        s_tlast,   // line_end
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // read_char[7:0] row_length[15:8] visible_count[23:16]
	output logic        m_tuser,   // row_valid
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int RW  = $clog2(STORED_ROWS);
	localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int FW  = $clog2(MAX_COLS + 1);
	localparam int XW  = (RW + 1 > 9) ? RW + 1 : 9;
	localparam int AWD = $clog2(STORED_ROWS * MAX_COLS);
	localparam int CXW = CW + 8;

	// ring helpers, operands below STORED_ROWS
	function automatic logic [RW-1:0] ring_add(input logic [RW-1:0] i, input logic [XW-1:0] by);
		logic [XW-1:0] s;
		s = XW'(i) + by;
		if (s >= XW'(STORED_ROWS)) s = s - XW'(STORED_ROWS);
		return s[RW-1:0];
	endfunction

	function automatic logic [RW-1:0] ring_sub(input logic [RW-1:0] i, input logic [RW-1:0] by);
		logic [XW-1:0] s;
		if (i >= by) s = XW'(i) - XW'(by);
		else s = XW'(i) + XW'(STORED_ROWS) - XW'(by);
		return s[RW-1:0];
	endfunction

	function automatic logic [XW-1:0] ring_span(input logic [RW-1:0] lo, input logic [RW-1:0] hi);
		return XW'(ring_sub(hi, lo)) + XW'(1);
	endfunction

	slrv_pkg::cfg_t cfg;

	slrv_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// request fields
	slrv_pkg::kind_t in_kind;
	logic [7:0]      in_char;
	logic [7:0]      in_amount;
	logic [7:0]      in_row;
	logic [6:0]      in_col;

	assign in_kind   = slrv_pkg::kind_t'(s_tuser);
	assign in_char   = s_tdata[7:0];
	assign in_amount = s_tdata[15:8];
	assign in_row    = s_tdata[23:16];
	assign in_col    = s_tdata[30:24];

	// ring state
	logic [RW-1:0] oldest_q, newest_q, vtop_q, vbot_q;
	logic          empty_q;
	logic [CW-1:0] fill_q;

	// handshake
	logic accept, out_en, rd_s1, out_valid_q, is_read;

	assign out_en   = !out_valid_q || m_tready;
	assign s_tready = !rd_s1 || out_en;
	assign accept   = s_tvalid && s_tready;
	assign is_read  = (in_kind == slrv_pkg::KIND_READ);

	// effective register values
	logic [XW-1:0] cols_x, lim_x;

	always_comb begin
		if (cfg.chars_per_line == 8'd0) cols_x = XW'(1);
		else if (XW'(cfg.chars_per_line) > XW'(MAX_COLS)) cols_x = XW'(MAX_COLS);
		else cols_x = XW'(cfg.chars_per_line);
		lim_x = (cfg.visible_limit == 8'd0) ? XW'(1) : XW'(cfg.visible_limit);
	end

	// append: open a row when needed, place the character
	logic          open_row;
	logic [RW-1:0] ob_o, nr_o, vt_b, vb_o, vt_o;
	logic [RW-1:0] wrow;
	logic [CW-1:0] wcol;
	logic [XW-1:0] col_next;
	logic [CW-1:0] fill_n;

	always_comb begin
		open_row = empty_q || (fill_q == '0) || (XW'(fill_q) >= cols_x);
		if (empty_q) begin
			ob_o = '0;
			nr_o = '0;
			vt_b = '0;
			vb_o = '0;
		end else begin
			vb_o = (vbot_q == newest_q) ? ring_add(vbot_q, XW'(1)) : vbot_q;
			nr_o = ring_add(newest_q, XW'(1));
			ob_o = (oldest_q == nr_o) ? ring_add(oldest_q, XW'(1)) : oldest_q;
			vt_b = vtop_q;
		end
		vt_o = (ring_span(vt_b, vb_o) > lim_x) ? ring_add(vt_b, XW'(1)) : vt_b;
		// the character lands on the new row, or on the current one mid-line
		wrow     = open_row ? nr_o : newest_q;
		wcol     = open_row ? '0 : fill_q;
		col_next = XW'(wcol) + XW'(1);
		fill_n   = ((col_next >= cols_x) || s_tlast) ? '0 : col_next[CW-1:0];
	end

	// scrolls, clamped to the rows beyond the viewport
	logic [RW-1:0] up_room, dn_room, up_used, dn_used;
	logic [XW-1:0] up_sel, dn_sel;

	always_comb begin
		up_room = ring_sub(vtop_q, oldest_q);
		dn_room = ring_sub(newest_q, vbot_q);
		up_sel  = (XW'(in_amount) < XW'(up_room)) ? XW'(in_amount) : XW'(up_room);
		dn_sel  = (XW'(in_amount) < XW'(dn_room)) ? XW'(in_amount) : XW'(dn_room);
		up_used = up_sel[RW-1:0];
		dn_used = dn_sel[RW-1:0];
	end

	// read lookup
	logic [XW-1:0]  count_x;
	logic           row_ok;
	logic [RW-1:0]  phys;
	logic [CXW-1:0] col_w;
	logic [7:0]     count_sat;

	always_comb begin
		count_x   = empty_q ? '0 : ring_span(vtop_q, vbot_q);
		row_ok    = XW'(in_row) < count_x;
		phys      = ring_add(vtop_q, XW'(in_row));
		col_w     = CXW'(in_col);
		count_sat = (count_x > XW'(255)) ? 8'd255 : count_x[7:0];
	end

	// memory ports
	logic           mem_we, mem_re;
	logic [AWD-1:0] char_waddr, char_raddr;

	assign mem_we     = accept && (in_kind == slrv_pkg::KIND_APPEND);
	assign mem_re     = accept && is_read;
	assign char_waddr = AWD'(wrow) * AWD'(MAX_COLS) + AWD'(wcol);
	assign char_raddr = AWD'(phys) * AWD'(MAX_COLS) + AWD'(col_w[CW-1:0]);

	logic [7:0]    char_mem [STORED_ROWS*MAX_COLS];
	logic [FW-1:0] fill_mem [STORED_ROWS];
	logic [7:0]    char_s1;
	logic [FW-1:0] fill_s1;

	// character store
	always_ff @(posedge clk) begin
		if (mem_we) char_mem[char_waddr] <= in_char;
		if (mem_re) char_s1 <= char_mem[char_raddr];
	end

	// row length store
	always_ff @(posedge clk) begin
		if (mem_we) fill_mem[wrow] <= FW'(col_next);
		if (mem_re) fill_s1 <= fill_mem[phys];
	end

	// pointer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			newest_q <= '0;
			vtop_q   <= '0;
			vbot_q   <= '0;
			empty_q  <= 1'b1;
			fill_q   <= '0;
		end else if (accept) begin
			unique case (in_kind)
				slrv_pkg::KIND_APPEND: begin
					if (open_row) begin
						oldest_q <= ob_o;
						newest_q <= nr_o;
						vtop_q   <= vt_o;
						vbot_q   <= vb_o;
						empty_q  <= 1'b0;
					end
					fill_q <= fill_n;
				end
				slrv_pkg::KIND_UP: begin
					if (!empty_q) begin
						vtop_q <= ring_sub(vtop_q, up_used);
						vbot_q <= ring_sub(vbot_q, up_used);
					end
				end
				slrv_pkg::KIND_DOWN: begin
					if (!empty_q) begin
						vtop_q <= ring_add(vtop_q, XW'(dn_used));
						vbot_q <= ring_add(vbot_q, XW'(dn_used));
					end
				end
				slrv_pkg::KIND_READ: ;
				default: ;
			endcase
		end
	end

	// read stage 1 control and payload
	logic [6:0] col_s1;
	logic [7:0] count_s1;
	logic       valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else if (s_tready) begin
			rd_s1 <= mem_re;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			col_s1   <= in_col;
			count_s1 <= count_sat;
			valid_s1 <= row_ok;
		end
	end

	// result formation
	logic [7:0] len_r, char_r;

	always_comb begin
		len_r  = valid_s1 ? 8'(fill_s1) : 8'd0;
		char_r = (valid_s1 && (XW'(col_s1) < XW'(fill_s1))) ? char_s1 : 8'd0;
	end

	// output register
	logic [23:0] out_data_q;
	logic        out_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_en) begin
			out_valid_q <= rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && rd_s1) begin
			out_data_q <= {count_s1, len_r, char_r};
			out_user_q <= valid_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule
